/* sv/sisks_pkg.sv */
`default_nettype none
package sisks_pkg;

	localparam logic signed [31:0] ENTRY_MAX = 32'sh7fff_ffff;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_READ   = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LOOK = 5'b00010,
		ST_WALK = 5'b00100,
		ST_PUT  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

endpackage
`default_nettype wire

/* sv/sorted_insert_keep_smallest_unit.sv */
`default_nettype none
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  mode, new_value, read_index
// out      output     out_valid / out_stall inserted, position, evicted_value, read_value
//
// one transaction at a time; an accepted insert compares one entry per step,
// moving each entry that is not smaller up one place until a smaller entry
// stops the walk; a single comparator and the table's one read port serialise
// the compare steps, walking from the last entry downward.
// arst_n clears the control state and the per-entry valid bits, so the table reads
// as all largest positive values right after reset without a clearing pass.
// out_stall holds the result in place and keeps in_stall high until it is taken.
module sorted_insert_keep_smallest_unit
	import sisks_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire                mode,
	input  wire signed [31:0]  new_value,
	input  wire        [3:0]   read_index,
	output logic               out_valid,
	input  wire                out_stall,
	output logic               inserted,
	output logic       [3:0]   position,
	output logic signed [31:0] evicted_value,
	output logic signed [31:0] read_value
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [8:0] DEPTH_W = 9'(DEPTH);

	state_t state_q;

	logic signed [31:0] mem [DEPTH];
	logic [DEPTH-1:0]   vld_q;
	logic signed [31:0] rd_data_q;
	logic               rd_vld_q;

	logic               mode_q;
	logic signed [31:0] value_q;
	logic [3:0]         ridx_q;
	logic [AW-1:0]      k_q;

	logic               res_ins_q;
	logic [3:0]         res_pos_q;
	logic signed [31:0] res_evict_q;
	logic signed [31:0] res_read_q;

	logic signed [31:0] eff;
	logic               gt;
	logic               ridx_ok;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic signed [31:0] wr_data;

	// an entry never written reads as ENTRY_MAX through its clear valid bit
	assign eff     = rd_vld_q ? rd_data_q : ENTRY_MAX;
	assign gt      = value_q > eff;
	assign ridx_ok = {5'd0, ridx_q} < DEPTH_W;

	always_comb begin
		rd_addr = LAST;
		wr_en   = 1'b0;
		wr_addr = k_q;
		wr_data = eff;
		unique case (state_q)
			ST_IDLE: begin
				rd_addr = (mode == MODE_READ) ? AW'(read_index) : LAST;
			end
			ST_LOOK: begin
				rd_addr = AW'(LAST - AW'(1));
			end
			ST_WALK: begin
				rd_addr = AW'(k_q - AW'(2));
				wr_en   = !gt;
			end
			ST_PUT: begin
				wr_en   = 1'b1;
				wr_data = value_q;
			end
			ST_DONE: begin
				rd_addr = LAST;
			end
			default: begin
				rd_addr = LAST;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_LOOK;
				ST_LOOK: begin
					if (mode_q == MODE_READ || gt) state_q <= ST_DONE;
					else state_q <= ST_WALK;
				end
				ST_WALK: if (gt || k_q == AW'(1)) state_q <= ST_PUT;
				ST_PUT:  state_q <= ST_DONE;
				ST_DONE: if (!out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					mode_q      <= mode;
					value_q     <= new_value;
					ridx_q      <= read_index;
					res_ins_q   <= 1'b0;
					res_pos_q   <= 4'd0;
					res_evict_q <= '0;
					res_read_q  <= '0;
				end
			end
			ST_LOOK: begin
				if (mode_q == MODE_READ) begin
					res_read_q <= ridx_ok ? eff : 32'sd0;
				end else if (!gt) begin
					res_evict_q <= eff;
					k_q         <= LAST;
				end
			end
			ST_WALK: begin
				// entry below is not smaller: it moves up one place
				if (!gt) begin
					k_q <= AW'(k_q - AW'(1));
				end
			end
			ST_PUT: begin
				res_ins_q <= 1'b1;
				res_pos_q <= 4'(k_q);
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign out_valid     = (state_q == ST_DONE);
	assign inserted      = res_ins_q;
	assign position      = res_pos_q;
	assign evicted_value = res_evict_q;
	assign read_value    = res_read_q;

endmodule
`default_nettype wire

/* bench/smallest_table_monitor.sv */
`default_nettype none
module smallest_table_monitor
	import sisks_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	input  wire                in_stall,
	input  wire                mode,
	input  wire signed [31:0]  new_value,
	input  wire        [3:0]   read_index,
	input  wire                out_valid,
	input  wire                out_stall,
	input  wire                inserted,
	input  wire        [3:0]   position,
	input  wire signed [31:0]  evicted_value,
	input  wire signed [31:0]  read_value,
	output int                 fail_count,
	output int                 outstanding
);

	typedef struct packed {
		logic               inserted;
		logic        [3:0]  position;
		logic signed [31:0] evicted_value;
		logic signed [31:0] read_value;
	} outcome_t;

	logic signed [31:0] smallest [DEPTH];
	outcome_t           pending_outcomes [$];

	initial begin
		for (int k = 0; k < DEPTH; k++) smallest[k] = ENTRY_MAX;
		fail_count  = 0;
		outstanding = 0;
	end

	// applies one transaction to the shadow table and returns the result it should give
	function automatic outcome_t apply_transaction(input logic m, input logic signed [31:0] v,
			input logic [3:0] ix);
		outcome_t r;
		int       place;
		int       k;
		r = '0;
		if (m == MODE_READ) begin
			if (ix < DEPTH) r.read_value = smallest[ix];
			return r;
		end
		if (v > smallest[DEPTH-1]) return r;
		place = DEPTH - 1;
		for (k = DEPTH - 1; k >= 0; k--) begin
			if (!(v > smallest[k])) place = k;
		end
		r.inserted      = 1'b1;
		r.position      = place[3:0];
		r.evicted_value = smallest[DEPTH-1];
		for (k = DEPTH - 1; k > place; k--) smallest[k] = smallest[k-1];
		smallest[place] = v;
		return r;
	endfunction

	always @(posedge clk) begin
		outcome_t exp_r;
		if (arst_n) begin
			if (in_valid && !in_stall)
				pending_outcomes.push_back(apply_transaction(mode, new_value, read_index));
			if (out_valid && !out_stall) begin
				if (pending_outcomes.size() == 0) begin
					fail_count = fail_count + 1;
					if (fail_count <= 10)
						$display("unexpected result: inserted=%0d position=%0d evicted=%0d read=%0d",
							inserted, position, evicted_value, read_value);
				end else begin
					exp_r = pending_outcomes.pop_front();
					if (exp_r.inserted !== inserted || exp_r.position !== position ||
							exp_r.evicted_value !== evicted_value ||
							exp_r.read_value !== read_value) begin
						fail_count = fail_count + 1;
						if (fail_count <= 10)
							$display("mismatch: inserted %0d/%0d position %0d/%0d evicted %0d/%0d read %0d/%0d (exp/act)",
								exp_r.inserted, inserted, exp_r.position, position,
								exp_r.evicted_value, evicted_value,
								exp_r.read_value, read_value);
					end
				end
			end
			outstanding = pending_outcomes.size();
		end
	end

endmodule
`default_nettype wire

/* bench/tb_sorted_insert_keep_smallest_unit.sv */
`default_nettype none
module tb_sorted_insert_keep_smallest_unit
	import sisks_pkg::*;
();

	localparam int     TABLE_DEPTH  = 16;
	localparam int     RANDOM_ITEMS = 1600;
	localparam int     CYCLE_LIMIT  = 600000;
	localparam longint VAL_MIN      = -64'sd2147483648;
	localparam longint VAL_MAX      = 64'sd2147483647;
	localparam logic signed [31:0] ENTRY_MIN = 32'sh8000_0000;

	logic               clk;
	logic               arst_n     = 1'b0;
	logic               in_valid   = 1'b0;
	logic               mode       = MODE_INSERT;
	logic signed [31:0] new_value  = '0;
	logic        [3:0]  read_index = '0;
	logic               out_stall  = 1'b0;
	wire                in_stall;
	wire                out_valid;
	wire                inserted;
	wire         [3:0]  position;
	wire signed  [31:0] evicted_value;
	wire signed  [31:0] read_value;

	int fail_count;
	int outstanding;
	int idle_pct  = 0;
	int stall_pct = 0;
	int cycle_count = 0;

	sorted_insert_keep_smallest_unit #(.DEPTH(TABLE_DEPTH)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .new_value(new_value), .read_index(read_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.inserted(inserted), .position(position),
		.evicted_value(evicted_value), .read_value(read_value)
	);

	smallest_table_monitor #(.DEPTH(TABLE_DEPTH)) monitor (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .new_value(new_value), .read_index(read_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.inserted(inserted), .position(position),
		.evicted_value(evicted_value), .read_value(read_value),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		out_stall   <= ($urandom_range(0, 99) < stall_pct);
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// holds the transaction until it is taken; returns at the accepting edge
	task automatic offer(input logic m, input logic signed [31:0] v, input logic [3:0] ix);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= m;
		new_value  <= v;
		read_index <= ix;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic offer_insert(input logic signed [31:0] v);
		offer(MODE_INSERT, v, 4'($urandom));
	endtask

	task automatic offer_read(input logic [3:0] ix);
		offer(MODE_READ, $urandom, ix);
	endtask

	initial begin
		longint             cursor;
		longint             pick_val;
		logic signed [31:0] last_offered;
		int                 pick;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fresh table reads as all largest values
		offer_read(4'd0);
		offer_read(4'd15);
		// equal to the last entry goes in at the front
		offer_insert(ENTRY_MAX);
		offer_insert(ENTRY_MIN);
		offer_insert(32'sd0);
		offer_insert(-32'sd1);
		offer_insert(32'sd0);
		for (int k = 1; k <= 10; k++) offer_insert(ENTRY_MAX - 32'(k * 977));
		offer_insert(32'sh7fff_0000);
		offer_insert(32'sh7000_0000);
		// table full now: larger than last is dropped, equal to last goes in
		offer_insert(ENTRY_MAX);
		offer_insert(ENTRY_MAX - 32'sd977);
		offer_read(4'd15);
		offer_read(4'd7);

		// values drift downward so the table keeps turning over
		last_offered = 32'sh7e00_0000;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			case (i / (RANDOM_ITEMS / 4))
				0:       begin idle_pct = 0;  stall_pct = 0;  end
				1:       begin idle_pct = 86; stall_pct = 0;  end
				2:       begin idle_pct = 0;  stall_pct = 86; end
				default: begin idle_pct = 31; stall_pct = 31; end
			endcase
			cursor = 64'sd2113929216 - longint'(i) * 64'sd2600000
				+ longint'($urandom_range(0, 2000000));
			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				offer_read(4'($urandom));
			end else if (pick < 28) begin
				pick_val = cursor + longint'($urandom_range(1, 400000000));
				if (pick_val > VAL_MAX) pick_val = VAL_MAX;
				offer_insert(pick_val[31:0]);
			end else if (pick < 36) begin
				offer_insert(last_offered);
			end else begin
				pick_val = cursor - longint'($urandom_range(0, 6000000));
				if (pick_val < VAL_MIN) pick_val = VAL_MIN;
				if (pick_val > VAL_MAX) pick_val = VAL_MAX;
				last_offered = pick_val[31:0];
				offer_insert(last_offered);
			end
		end
		in_valid <= 1'b0;

		// let the checker log the last accepted transaction first
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
